// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_DEPTH_DEF = 8;
    localparam int SPQ_DATA_W    = 32;
    localparam int SPQ_PRIO_W    = 16;
    localparam int SPQ_OCC_W     = 4;

    localparam logic SPQ_OP_INSERT = 1'b0;
    localparam logic SPQ_OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                         operation;
        logic [SPQ_DATA_W-1:0]        entry_data;
        logic signed [SPQ_PRIO_W-1:0] entry_priority;
    } t_in_req;

    typedef struct packed {
        logic                         success;
        logic [SPQ_DATA_W-1:0]        head_data;
        logic signed [SPQ_PRIO_W-1:0] head_priority;
        logic [SPQ_OCC_W-1:0]         occupancy;
    } t_out_rsp;

    typedef struct packed {
        logic [SPQ_DATA_W-1:0]        data;
        logic signed [SPQ_PRIO_W-1:0] prio;
    } t_slot;

endpackage

// ===== src/spq_store.sv =====
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module spq_store
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH_DEF,
    localparam int IDXW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IDXW-1:0] i_wr_addr,
    input  t_slot           i_wr_slot,
    input  logic [IDXW-1:0] i_rd_addr,
    output t_slot           o_rd_slot
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= r_mem[i_rd_addr];
    end

    assign o_rd_slot = r_rd_slot;

endmodule

// ===== src/sorted_priority_queue.sv =====
// Top level: sorted priority queue, sequencer walking a single slot memory.
// Sequence: an insert into a non-empty queue walks from the tail toward the head,
//   shifting entries back; a remove walks from the head over every entry; a full or
//   empty reject goes straight to the finish state, which loads the result register.
// Throughput: one request at a time; one slot read and at most one slot write a cycle.
// Reset: synchronous active-low; clears the count, sequencer and result valid.
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    localparam int IDXW = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // waiting for a request
        S_INS  = 5'b00010,   // walk from tail toward head, shifting lower entries back
        S_PUT  = 5'b00100,   // drop the new entry into slot 0
        S_REM  = 5'b01000,   // walk from head, moving entries up
        S_FIN  = 5'b10000    // hand result to the output register
    } t_state;

    t_state          r_state, n_state;
    logic [IDXW-1:0] r_idx, n_idx;     // slot whose read data arrives this cycle
    logic [CW-1:0]   r_count, n_count;
    logic            r_ok, n_ok;
    t_slot           r_head, n_head;
    t_in_req         r_req;

    logic            r_out_valid;
    t_out_rsp        r_out;

    logic            in_accept;
    logic            out_load;
    logic            higher;           // compare: new entry beats the slot read

    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    t_slot           wr_slot;
    logic [IDXW-1:0] rd_addr;
    t_slot           rd_slot;
    t_slot           new_slot;

    spq_store #(
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_slot (wr_slot),
        .i_rd_addr (rd_addr),
        .o_rd_slot (rd_slot)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign new_slot.data = r_req.entry_data;
    assign new_slot.prio = r_req.entry_priority;

    // Strictly greater: equal priorities keep arrival order
    assign higher = $signed(r_req.entry_priority) > $signed(rd_slot.prio);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_ok    = r_ok;
        n_head  = r_head;
        wr_en   = 1'b0;
        wr_addr = r_idx + IDXW'(1);
        wr_slot = rd_slot;
        rd_addr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_ok   = 1'b0;
                    n_head = '0;
                    n_idx  = '0;
                    rd_addr = '0;
                    if (i_in_req.operation == SPQ_OP_INSERT) begin
                        if (r_count == DEPTH_C) begin
                            n_state = S_FIN;           // full: fail
                        end else if (r_count == '0) begin
                            n_state = S_PUT;
                        end else begin
                            // start at the tail
                            n_idx   = IDXW'(r_count - CW'(1));
                            rd_addr = IDXW'(r_count - CW'(1));
                            n_state = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = S_FIN;           // empty: fail
                        end else begin
                            n_state = S_REM;
                        end
                    end
                end
            end

            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + IDXW'(1);
                if (higher) begin
                    wr_slot = rd_slot;                 // shift back one slot
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx   = r_idx - IDXW'(1);
                        rd_addr = r_idx - IDXW'(1);
                    end
                end else begin
                    wr_slot = new_slot;                // lands behind this slot
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end
            end

            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_slot = new_slot;
                n_count = r_count + CW'(1);
                n_ok    = 1'b1;
                n_state = S_FIN;
            end

            S_REM: begin
                if (r_idx == '0) begin
                    n_head = rd_slot;                  // head leaves
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx - IDXW'(1);
                    wr_slot = rd_slot;
                end
                if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + IDXW'(1);
                    rd_addr = r_idx + IDXW'(1);
                end
            end

            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_ok   <= n_ok;
        r_head <= n_head;
        if (in_accept) begin
            r_req <= i_in_req;
        end
        if (out_load) begin
            r_out.success       <= r_ok;
            r_out.head_data     <= r_head.data;
            r_out.head_priority <= r_head.prio;
            r_out.occupancy     <= SPQ_OCC_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond queue depth");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_PUT) |-> (r_count < DEPTH_C))
        else $error("insert walk on a full queue");

    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish state");

    a_rem_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM) |-> (r_count != '0))
        else $error("remove walk on an empty queue");

endmodule
